[rtl/aabb_pkg.sv]
`timescale 1ns / 1ps
// types, codes and span arithmetic for the box collision resolver
// depends on nothing; used by every module of the block
package aabb_pkg;

   localparam int POS_W     = 24;
   localparam int EDGE_W    = 25;
   localparam int DIFF_W    = 26;
   localparam int LEN_W     = 16;
   localparam int VEL_W     = 16;
   localparam int IDX_W     = 4;
   localparam int CONTACT_W = 4;
   localparam int OVL_W     = 16;

   localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_MOVE  = 1'b1;

   // result kinds
   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // direction of travel at a hit, also the contact bit index
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   // contact bit that the falling flag watches
   localparam int CONTACT_TOP = 2;

   // axis select
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_X_SETUP,
      ST_X_WALK,
      ST_Y_SETUP,
      ST_Y_WALK,
      ST_FINAL
   } state_type;

   // one axis of a box: low edge and low edge plus length
   typedef struct packed {
      logic signed [POS_W-1:0]  lo;
      logic signed [EDGE_W-1:0] hi;
   } span_type;

   typedef struct packed {
      span_type x;
      span_type y;
   } box_type;

   // obstacle table entry as read out of the memory
   typedef struct packed {
      logic    valid;
      box_type box;
   } entry_type;

   // outcome of testing one obstacle against the body
   typedef struct packed {
      logic             hit;
      logic             emit;
      logic [1:0]       side;
      logic [OVL_W-1:0] ovl_x;
      logic [OVL_W-1:0] ovl_y;
      span_type         x;
      span_type         y;
   } hit_type;

   // one result item
   typedef struct packed {
      logic                     kind;
      logic [IDX_W-1:0]         other_index;
      logic [OVL_W-1:0]         overlap_x;
      logic [OVL_W-1:0]         overlap_y;
      logic [1:0]               direction;
      logic signed [POS_W-1:0]  new_pos_x;
      logic signed [POS_W-1:0]  new_pos_y;
      logic signed [VEL_W-1:0]  new_vel_x;
      logic signed [VEL_W-1:0]  new_vel_y;
      logic [CONTACT_W-1:0]     contacts;
      logic                     falling;
      logic                     last;
   } rsp_type;

   // move a span by d, saturating the low edge to the position range
   function automatic span_type shift_span(span_type s, logic [LEN_W-1:0] len,
                                           logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] sum_lo;
      logic signed [DIFF_W-1:0] sum_hi;
      logic signed [EDGE_W-1:0] len_e;
      span_type                 r;
      sum_lo = DIFF_W'($signed(s.lo)) + d;
      sum_hi = DIFF_W'($signed(s.hi)) + d;
      len_e  = EDGE_W'($signed({1'b0, len}));
      if (sum_lo < DIFF_W'(POS_MIN)) begin
         r.lo = POS_MIN;
         r.hi = EDGE_W'(POS_MIN) + len_e;
      end else if (sum_lo > DIFF_W'(POS_MAX)) begin
         r.lo = POS_MAX;
         r.hi = EDGE_W'(POS_MAX) + len_e;
      end else begin
         r.lo = sum_lo[POS_W-1:0];
         r.hi = sum_hi[EDGE_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/aabb_obstacle_mem.sv]
`timescale 1ns / 1ps
// obstacle table: box memory with registered read, valid bits in flip-flops
// depends on aabb_pkg
module aabb_obstacle_mem #(
   parameter int MAX_OBSTACLES = 16,
   localparam int IW = $clog2(MAX_OBSTACLES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  logic                wr_valid,
   input  aabb_pkg::box_type   wr_box,
   input  logic                rd_en,
   input  logic [IW-1:0]       rd_addr,
   output aabb_pkg::entry_type rd_data
);
   import aabb_pkg::*;

   box_type                  box_mem [MAX_OBSTACLES];
   box_type                  rd_box_ff;
   logic [MAX_OBSTACLES-1:0] valid_ff;
   logic                     rd_valid_ff;

   // box storage, contents undefined until written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[wr_addr] <= wr_box;
      end
      if (rd_en) begin
         rd_box_ff <= box_mem[rd_addr];
      end
   end

   // valid bits cleared at reset, read alongside the box
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = {rd_valid_ff, rd_box_ff};

endmodule

[rtl/aabb_axis_unit.sv]
`timescale 1ns / 1ps
// overlap test and push-out of the body against one obstacle on one axis
// depends on aabb_pkg
module aabb_axis_unit (
   input  logic                                    axis_sel,
   input  aabb_pkg::span_type                      body_x,
   input  aabb_pkg::span_type                      body_y,
   input  logic [aabb_pkg::LEN_W-1:0]              box_w,
   input  logic [aabb_pkg::LEN_W-1:0]              box_h,
   input  logic signed [aabb_pkg::VEL_W-1:0]       vel,
   input  aabb_pkg::entry_type                     ent,
   input  logic                                    ent_live,
   input  logic [aabb_pkg::CONTACT_W-1:0]          prior,
   output aabb_pkg::hit_type                       result
);
   import aabb_pkg::*;

   logic signed [DIFF_W-1:0] d_x1;
   logic signed [DIFF_W-1:0] d_x2;
   logic signed [DIFF_W-1:0] d_y1;
   logic signed [DIFF_W-1:0] d_y2;
   logic signed [DIFF_W-1:0] ov_x;
   logic signed [DIFF_W-1:0] ov_y;
   logic signed [DIFF_W-1:0] ov;
   logic signed [DIFF_W-1:0] push;
   logic                     overlap;
   logic                     vel_nz;
   logic                     vel_pos;

   // edge distances; all positive means strict overlap
   assign d_x1 = DIFF_W'($signed(body_x.hi)) - DIFF_W'($signed(ent.box.x.lo));
   assign d_x2 = DIFF_W'($signed(ent.box.x.hi)) - DIFF_W'($signed(body_x.lo));
   assign d_y1 = DIFF_W'($signed(body_y.hi)) - DIFF_W'($signed(ent.box.y.lo));
   assign d_y2 = DIFF_W'($signed(ent.box.y.hi)) - DIFF_W'($signed(body_y.lo));

   assign overlap = (d_x1 > 0) && (d_x2 > 0) && (d_y1 > 0) && (d_y2 > 0);

   // minimum penetration per axis
   assign ov_x = (d_x1 < d_x2) ? d_x1 : d_x2;
   assign ov_y = (d_y1 < d_y2) ? d_y1 : d_y2;
   assign ov   = (axis_sel == AXIS_Y) ? ov_y : ov_x;

   assign vel_nz  = (vel != '0);
   assign vel_pos = vel_nz && !vel[VEL_W-1];
   assign push    = vel_pos ? -ov : ov;

   // push out against the direction of travel
   always_comb begin
      result.hit   = ent_live && ent.valid && overlap && vel_nz;
      result.side  = {axis_sel, !vel_pos};
      result.emit  = result.hit && !prior[result.side];
      result.ovl_x = ov_x[OVL_W-1:0];
      result.ovl_y = ov_y[OVL_W-1:0];
      result.x     = body_x;
      result.y     = body_y;
      if (result.hit) begin
         if (axis_sel == AXIS_Y) begin
            result.y = shift_span(body_y, box_h, push);
         end else begin
            result.x = shift_span(body_x, box_w, push);
         end
      end
   end

endmodule

[rtl/aabb_axis_collision_resolver.sv]
`timescale 1ns / 1ps
// a write item gives no result; a move item gives its collision events first and then
// its final result; no new request is taken until the final result has been loaded
// each move makes two walks, x then y, of the obstacle
// memory at one entry per cycle through its single read port; output stalls pause the walk
// reset clears the valid bits and contact history at once, no clearing pass; the box
// memory itself is not cleared, and its contents are only used behind a set valid bit
module aabb_axis_collision_resolver #(
   parameter int MAX_OBSTACLES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [3:0]         req_entry_index,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic [15:0]        req_box_w,
   input  logic [15:0]        req_box_h,
   input  logic signed [15:0] req_delta_x,
   input  logic signed [15:0] req_delta_y,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic               req_entry_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic [3:0]         rsp_other_index,
   output logic [15:0]        rsp_overlap_x,
   output logic [15:0]        rsp_overlap_y,
   output logic [1:0]         rsp_direction,
   output logic signed [23:0] rsp_new_pos_x,
   output logic signed [23:0] rsp_new_pos_y,
   output logic signed [15:0] rsp_new_vel_x,
   output logic signed [15:0] rsp_new_vel_y,
   output logic [3:0]         rsp_contacts,
   output logic               rsp_falling,
   output logic               rsp_last
);
   import aabb_pkg::*;

   localparam int IW = $clog2(MAX_OBSTACLES);
   localparam int CW = $clog2(MAX_OBSTACLES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OBSTACLES);
   localparam logic [4:0]    MAX5    = 5'(MAX_OBSTACLES);

   state_type state_ff, state_in;

   // handshake and control
   logic req_acc, acc_write, acc_move, req_in_table;
   logic out_free, walk, step, issue, pass_done, x_setup, y_setup, load_fin, load_evt;
   logic axis_sel;
   logic [4:0]    req_idx5;
   logic [IW-1:0] req_addr;

   // walk counters
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          proc_vld_ff, proc_vld_in;
   logic [IW-1:0] proc_idx_ff, proc_idx_in;
   logic [4:0]    proc_idx5;
   logic          skip;

   // body of the move in progress
   span_type                bx_ff, bx_in, by_ff, by_in;
   logic [LEN_W-1:0]        bw_ff, bw_in, bh_ff, bh_in;
   logic signed [VEL_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [VEL_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [IDX_W-1:0]        own_ff, own_in;
   logic                    own_tab_ff, own_tab_in;
   logic [CONTACT_W-1:0]    pri_ff, pri_in;
   logic [CONTACT_W-1:0]    contacts_ff, contacts_in;
   logic [4:0]              own5;

   // contact history per entry
   logic [CONTACT_W-1:0] prior_ff [MAX_OBSTACLES];
   logic [CONTACT_W-1:0] prior_rd;

   // memory and axis unit
   box_type   wr_box;
   entry_type rd_data;
   hit_type   hit;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign req_acc      = req_valid && !req_stall;
   assign acc_write    = req_acc && (req_command == CMD_WRITE);
   assign acc_move     = req_acc && (req_command == CMD_MOVE);
   assign req_idx5     = {1'b0, req_entry_index};
   assign req_addr     = req_idx5[IW-1:0];
   assign req_in_table = (req_idx5 < MAX5);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_move) state_in = ST_X_SETUP;
         end
         ST_X_SETUP: begin
            state_in = ST_X_WALK;
         end
         ST_X_WALK: begin
            if (pass_done) state_in = ST_Y_SETUP;
         end
         ST_Y_SETUP: begin
            state_in = ST_Y_WALK;
         end
         ST_Y_WALK: begin
            if (pass_done) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state decoded controls
   always_comb begin
      req_stall = 1'b1;
      walk      = 1'b0;
      x_setup   = 1'b0;
      y_setup   = 1'b0;
      load_fin  = 1'b0;
      axis_sel  = AXIS_X;
      unique case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_X_SETUP: x_setup   = 1'b1;
         ST_X_WALK:  walk      = 1'b1;
         ST_Y_SETUP: y_setup   = 1'b1;
         ST_Y_WALK: begin
            walk     = 1'b1;
            axis_sel = AXIS_Y;
         end
         ST_FINAL:   load_fin  = out_free;
         default:    req_stall = 1'b1;
      endcase
   end

   // walk steps only while the result register can take an item
   assign step      = walk && out_free;
   assign issue     = step && (cnt_ff != MAX_CNT);
   assign pass_done = step && (cnt_ff == MAX_CNT);
   assign load_evt  = step && hit.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // obstacle write data: both edges stored per axis
   always_comb begin
      wr_box.x.lo = req_pos_x;
      wr_box.x.hi = EDGE_W'(req_pos_x) + EDGE_W'({1'b0, req_box_w});
      wr_box.y.lo = req_pos_y;
      wr_box.y.hi = EDGE_W'(req_pos_y) + EDGE_W'({1'b0, req_box_h});
   end

   aabb_obstacle_mem #(
      .MAX_OBSTACLES(MAX_OBSTACLES)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (acc_write && req_in_table),
      .wr_addr  (req_addr),
      .wr_valid (req_entry_valid),
      .wr_box   (wr_box),
      .rd_en    (issue),
      .rd_addr  (cnt_ff[IW-1:0]),
      .rd_data  (rd_data)
   );

   // own entry is skipped when it lies in the table
   assign proc_idx5 = 5'(proc_idx_ff);
   assign own5      = {1'b0, own_ff};
   assign skip      = own_tab_ff && (proc_idx5 == own5);

   aabb_axis_unit u_axis (
      .axis_sel (axis_sel),
      .body_x   (bx_ff),
      .body_y   (by_ff),
      .box_w    (bw_ff),
      .box_h    (bh_ff),
      .vel      ((axis_sel == AXIS_Y) ? vy_ff : vx_ff),
      .ent      (rd_data),
      .ent_live (proc_vld_ff && !skip),
      .prior    (pri_ff),
      .result   (hit)
   );

   // walk counter and read pipeline tag
   always_comb begin
      cnt_in      = cnt_ff;
      proc_vld_in = proc_vld_ff;
      proc_idx_in = proc_idx_ff;
      if (acc_move || y_setup) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (!walk) begin
         proc_vld_in = 1'b0;
      end else if (step) begin
         proc_vld_in = issue;
      end
      if (issue) begin
         proc_idx_in = cnt_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         proc_vld_ff <= proc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= proc_idx_in;
   end

   // contact history read at acceptance
   assign prior_rd = req_in_table ? prior_ff[req_addr] : '0;

   // body state: load, apply deltas, then pushes from the walk
   always_comb begin
      bx_in       = bx_ff;
      by_in       = by_ff;
      bw_in       = bw_ff;
      bh_in       = bh_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      own_in      = own_ff;
      own_tab_in  = own_tab_ff;
      pri_in      = pri_ff;
      contacts_in = contacts_ff;
      if (acc_move) begin
         bx_in       = wr_box.x;
         by_in       = wr_box.y;
         bw_in       = req_box_w;
         bh_in       = req_box_h;
         dx_in       = req_delta_x;
         dy_in       = req_delta_y;
         vx_in       = req_vel_x;
         vy_in       = req_vel_y;
         own_in      = req_entry_index;
         own_tab_in  = req_in_table;
         pri_in      = prior_rd;
         contacts_in = '0;
      end else if (x_setup) begin
         bx_in = shift_span(bx_ff, bw_ff, DIFF_W'(dx_ff));
      end else if (y_setup) begin
         by_in = shift_span(by_ff, bh_ff, DIFF_W'(dy_ff));
      end else if (step && hit.hit) begin
         bx_in = hit.x;
         by_in = hit.y;
         if (axis_sel == AXIS_Y) begin
            vy_in = '0;
         end else begin
            vx_in = '0;
         end
         contacts_in[hit.side] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      bw_ff       <= bw_in;
      bh_ff       <= bh_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      own_ff      <= own_in;
      own_tab_ff  <= own_tab_in;
      pri_ff      <= pri_in;
      contacts_ff <= contacts_in;
   end

   // contact history written back when the final item is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_OBSTACLES; i++) begin
            prior_ff[i] <= '0;
         end
      end else if (load_fin && own_tab_ff) begin
         prior_ff[own5[IW-1:0]] <= contacts_ff;
      end
   end

   // result item: collision event or final move result
   always_comb begin
      rsp_in = rsp_ff;
      if (load_evt) begin
         rsp_in             = '0;
         rsp_in.kind        = KIND_EVENT;
         rsp_in.other_index = proc_idx5[IDX_W-1:0];
         rsp_in.overlap_x   = hit.ovl_x;
         rsp_in.overlap_y   = hit.ovl_y;
         rsp_in.direction   = hit.side;
         rsp_in.last        = 1'b0;
      end else if (load_fin) begin
         rsp_in           = '0;
         rsp_in.kind      = KIND_FINAL;
         rsp_in.new_pos_x = bx_ff.lo;
         rsp_in.new_pos_y = by_ff.lo;
         rsp_in.new_vel_x = vx_ff;
         rsp_in.new_vel_y = vy_ff;
         rsp_in.contacts  = contacts_ff;
         rsp_in.falling   = pri_ff[CONTACT_TOP] && !contacts_ff[CONTACT_TOP];
         rsp_in.last      = 1'b1;
      end
      rsp_valid_in = (load_evt || load_fin) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_other_index = rsp_ff.other_index;
   assign rsp_overlap_x   = rsp_ff.overlap_x;
   assign rsp_overlap_y   = rsp_ff.overlap_y;
   assign rsp_direction   = rsp_ff.direction;
   assign rsp_new_pos_x   = rsp_ff.new_pos_x;
   assign rsp_new_pos_y   = rsp_ff.new_pos_y;
   assign rsp_new_vel_x   = rsp_ff.new_vel_x;
   assign rsp_new_vel_y   = rsp_ff.new_vel_y;
   assign rsp_contacts    = rsp_ff.contacts;
   assign rsp_falling     = rsp_ff.falling;
   assign rsp_last        = rsp_ff.last;

`ifndef SYNTHESIS
   // a strict overlap always has depth on both axes
   a_event_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_EVENT)) |->
         ((rsp_overlap_x != '0) && (rsp_overlap_y != '0)))
      else $error("collision event with zero overlap depth");

   // events raised on the x walk report a horizontal direction
   a_x_direction: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_X_WALK) && load_evt) |=>
         ((rsp_direction == DIR_RIGHT) || (rsp_direction == DIR_LEFT)))
      else $error("x walk event with vertical direction");

   // only the final item of a move carries the last mark
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_FINAL) == rsp_last))
      else $error("result kind and last mark disagree");

   // the walk finishes before the final item is loaded
   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      load_fin |-> (!proc_vld_ff && (cnt_ff == MAX_CNT)))
      else $error("final item loaded with the walk still running");
`endif

endmodule
